FILE: hdl/sha256_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256 package
// Shared types, constants and round functions for the byte-stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store_byte;   // shift incoming byte into the block
      logic pad_byte;     // shift padding byte into the block
      logic load;         // copy hash words into working regs, clear round
      logic round;        // run one compression round
      logic finish;       // fold working regs into hash words
      logic add_block;    // count 512 bits done
      logic clear_fill;   // fill position back to zero
      logic restart;      // initial hash values, counters cleared
      logic shift_out;    // advance digest word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       fill_full;   // fill position is 63
      logic       len_here;    // block being padded carries the length
      logic       pad_done;    // fill position 63 while padding
      logic       last_round;  // round counter is 63
      logic [2:0] out_idx;
   } status_type;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam int unsigned LEN_POS = 56;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
      ror32 = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] a);
      big_sig0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] e);
      big_sig1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] a);
      small_sig0 = ror32(a, 7) ^ ror32(a, 18) ^ (a >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] b);
      small_sig1 = ror32(b, 17) ^ ror32(b, 19) ^ (b >> 10);
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sha256_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256 controller
// Sequences byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
   import sha256_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_byte_present,
   input  wire logic       req_end_of_message,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire status_type stat,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      end_ff, end_in;     // message end pending for this block
   logic      final_ff, final_in; // block now compressing is the last one

   logic accept;
   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      final_in = final_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               end_in = req_end_of_message;
               if (req_byte_present && stat.fill_full) begin
                  final_in = 1'b0;
                  state_in = ST_LOAD;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // first pad byte carries the mark, then zeros and length
            if (stat.pad_done) begin
               final_in = stat.len_here;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  state_in = ST_ROUND;
         ST_ROUND: if (stat.last_round) state_in = ST_FINAL;
         ST_FINAL: begin
            if (final_ff)    state_in = ST_OUT;
            else if (end_ff) state_in = ST_PAD;
            else             state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_stall && stat.out_idx == 3'd7) begin
               end_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall      = 1'b0;
            cmd.store_byte = req_valid && req_byte_present;
         end
         ST_PAD:   cmd.pad_byte = 1'b1;
         ST_LOAD:  cmd.load = 1'b1;
         ST_ROUND: cmd.round = 1'b1;
         ST_FINAL: begin
            cmd.finish     = 1'b1;
            cmd.add_block  = !end_ff || !final_ff;
            cmd.clear_fill = 1'b1;
         end
         ST_OUT: begin
            rsp_valid     = 1'b1;
            cmd.shift_out = !rsp_stall;
            cmd.restart   = !rsp_stall && stat.out_idx == 3'd7;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         final_ff <= final_in;
      end
   end

   // rounds run only after a load
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && $past(state_ff) != ST_ROUND |-> $past(state_ff) == ST_LOAD)
      else $error("round without load");
   // input stalled while results are offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken during output");
   // output ends in idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && !rsp_stall && stat.out_idx == 3'd7 |=> state_ff == ST_IDLE)
      else $error("output did not end");

endmodule
`default_nettype wire

FILE: hdl/sha256_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256 datapath
// Schedule window that also gathers the block, round unit, hash words and
// length counter.
// ----------------------------------------------------------------------------
module sha256_dp
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_data_byte,
   input  wire cmd_type     cmd,
   output status_type       stat,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   logic [31:0] hash_ff [8];
   logic [31:0] work_ff [8];
   logic [31:0] sched_ff [16];     // schedule window, bytes shift in while filling
   logic [5:0]  fill_ff;
   logic        marked_ff;         // pad mark already written
   logic        two_blk_ff;        // length goes into a second block
   logic [63:0] total_len_ff;      // message length in bits, taken at the mark
   logic [63:0] bits_ff;
   logic [5:0]  rnd_ff;
   logic [2:0]  oidx_ff;

   logic [63:0] total;
   logic [7:0]  pad_val, byte_in;
   logic [31:0] w_new, t1, t2, w_cur;
   logic [2:0]  len_sel;

   assign total   = bits_ff + {55'd0, fill_ff, 3'd0};
   assign len_sel = 3'(~fill_ff[2:0]);
   assign w_cur   = sched_ff[0];

   // padding byte at current fill position
   always_comb begin
      if (!marked_ff)
         pad_val = PAD_MARK;
      else if (fill_ff >= 6'(LEN_POS) && !two_blk_ff)
         pad_val = total_len_ff[8*len_sel +: 8];
      else
         pad_val = 8'd0;
   end

   assign byte_in = cmd.pad_byte ? pad_val : req_data_byte;

   assign w_new = small_sig1(sched_ff[14]) + sched_ff[9] + small_sig0(sched_ff[1]) + sched_ff[0];
   assign t1 = work_ff[7] + big_sig1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6])) + ROUND_K[rnd_ff] + w_cur;
   assign t2 = big_sig0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]));

   assign stat.fill_full  = fill_ff == 6'd63;
   assign stat.pad_done   = fill_ff == 6'd63;
   assign stat.len_here   = marked_ff ? !two_blk_ff : (fill_ff < 6'(LEN_POS));
   assign stat.last_round = rnd_ff == 6'd63;
   assign stat.out_idx    = oidx_ff;

   assign rsp_digest_word = hash_ff[oidx_ff];
   assign rsp_word_index  = oidx_ff;
   assign rsp_last_word   = oidx_ff == 3'd7;

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= INIT_HASH[i];
         fill_ff    <= 6'd0;
         bits_ff    <= 64'd0;
         marked_ff  <= 1'b0;
         two_blk_ff <= 1'b0;
         oidx_ff    <= 3'd0;
      end else begin
         // message and pad bytes shift into the window, first byte ends up on top
         if (cmd.store_byte || cmd.pad_byte) begin
            for (int i = 0; i < 15; i++)
               sched_ff[i] <= {sched_ff[i][23:0], sched_ff[i+1][31:24]};
            sched_ff[15] <= {sched_ff[15][23:0], byte_in};
            fill_ff      <= fill_ff + 6'd1;
         end
         if (cmd.pad_byte) begin
            if (!marked_ff) begin
               total_len_ff <= total;
               two_blk_ff   <= fill_ff >= 6'(LEN_POS);
            end
            marked_ff <= 1'b1;
         end
         // load working words
         if (cmd.load) begin
            for (int i = 0; i < 8; i++) work_ff[i] <= hash_ff[i];
            rnd_ff <= 6'd0;
         end
         // one round per cycle
         if (cmd.round) begin
            for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i+1];
            sched_ff[15] <= w_new;
            work_ff[7] <= work_ff[6];
            work_ff[6] <= work_ff[5];
            work_ff[5] <= work_ff[4];
            work_ff[4] <= work_ff[3] + t1;
            work_ff[3] <= work_ff[2];
            work_ff[2] <= work_ff[1];
            work_ff[1] <= work_ff[0];
            work_ff[0] <= t1 + t2;
            rnd_ff     <= rnd_ff + 6'd1;
         end
         if (cmd.finish) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
            if (two_blk_ff && marked_ff) two_blk_ff <= 1'b0;
         end
         if (cmd.clear_fill) fill_ff <= 6'd0;
         if (cmd.add_block && !marked_ff) bits_ff <= bits_ff + 64'd512;
         if (cmd.shift_out) oidx_ff <= oidx_ff + 3'd1;
      end
   end

   // fill position never moves while rounds run
   assert property (@(posedge clock) disable iff (reset)
      cmd.round |=> $stable(fill_ff))
      else $error("fill moved during rounds");
   // digest index and bit count are zero after restart
   assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> oidx_ff == 3'd0 && bits_ff == 64'd0)
      else $error("restart incomplete");
   // round counter wraps only into finish
   assert property (@(posedge clock) disable iff (reset)
      cmd.round && rnd_ff == 6'd63 |=> cmd.finish)
      else $error("rounds overran");

endmodule
`default_nettype wire

FILE: hdl/sha256_byte_stream_hasher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// a byte that does not fill the block is stored while idle; a block-filling byte
// is followed by the load, the 64 one-per-cycle compression rounds and the fold
// end of message: pad bytes up to the block end, then the block is compressed,
// with a second padded block when 56 or more bytes are held, then 8 digest words
// input is stalled while a block is compressed or the digest is put out
// reset: synchronous, restores the initial hash, clears fill, bit and index counters
// ----------------------------------------------------------------------------
// sha256 byte stream hasher
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top
   import sha256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   cmd_type    cmd;
   status_type stat;

   // sequencing
   sha256_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_byte_present(req_byte_present), .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   // storage and arithmetic
   sha256_dp u_dp (
      .clock(clock), .reset(reset),
      .req_data_byte(req_data_byte),
      .cmd(cmd), .stat(stat),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

endmodule
`default_nettype wire

FILE: dv/sha256_byte_stream_hasher_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256 byte stream hasher test
// Drives byte words into the hasher, predicts each digest with a local
// SHA-256 model and checks every digest word in order, with random idling
// on both sides and long receiver hold-off.
// ----------------------------------------------------------------------------

// scoreboard: local hash model plus queue of pending digest words
class digest_scoreboard;
   logic [31:0] hash_st [8];
   logic [7:0]  blk [64];
   int unsigned fill;
   logic [63:0] bits_hashed;
   logic [31:0] pend_word [$];
   logic [2:0]  pend_idx [$];
   logic        pend_last [$];
   int unsigned errors;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam logic [31:0] KR [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function new();
      errors = 0;
      start_message();
   endfunction

   function void start_message();
      hash_st = IV;
      foreach (blk[i]) blk[i] = 8'h00;
      fill = 0;
      bits_hashed = 64'd0;
   endfunction

   function logic [31:0] rotr(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   // 64-round compression of the current block into the hash state
   function void compress();
      logic [31:0] w [64];
      logic [31:0] s [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      s = hash_st;
      for (int i = 0; i < 64; i++) begin
         t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + KR[i] + w[i];
         t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
         s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
         s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_st[i] += s[i];
   endfunction

   // note one accepted input word
   function void note_input(logic [7:0] data, logic present, logic eom);
      logic [63:0] total;
      int unsigned p;
      if (present) begin
         blk[fill] = data;
         fill++;
         if (fill == 64) begin
            compress();
            bits_hashed += 64'd512;
            fill = 0;
         end
      end
      if (!eom) return;
      total = bits_hashed + 64'(fill) * 8;
      p = fill;
      blk[p] = 8'h80;
      p++;
      // length does not fit: pad out and use an extra block
      if (p > 56) begin
         for (int i = p; i < 64; i++) blk[i] = 8'h00;
         compress();
         p = 0;
      end
      for (int i = p; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63-i] = total[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         pend_word.push_back(hash_st[i]);
         pend_idx.push_back(3'(i));
         pend_last.push_back(i == 7);
      end
      start_message();
   endfunction

   // compare one digest word against the oldest pending one
   function void check_result(logic [31:0] word, logic [2:0] idx, logic last);
      logic [31:0] ew;
      logic [2:0]  ei;
      logic        el;
      if (pend_word.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected digest word %h idx %0d last %0d", word, idx, last);
         return;
      end
      ew = pend_word.pop_front();
      ei = pend_idx.pop_front();
      el = pend_last.pop_front();
      if (word !== ew || idx !== ei || last !== el) begin
         errors++;
         if (errors <= 10)
            $display("digest mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                     ew, ei, el, word, idx, last);
      end
   endfunction

   function int unsigned pending();
      return pend_word.size();
   endfunction
endclass

module sha256_byte_stream_hasher_top_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_byte_present = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard digest_sb = new();
   bit quiet_phase = 0;     // no idling on either side
   int holdoff_cycles = 0;  // receiver hold-off request
   int unsigned words_sent = 0;

   sha256_byte_stream_hasher_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_byte_present(req_byte_present),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   always #10 clock = ~clock;

   // run limit
   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // accepted input and result words go to the scoreboard
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            digest_sb.note_input(req_data_byte, req_byte_present, req_end_of_message);
         if (rsp_valid && !rsp_stall)
            digest_sb.check_result(rsp_digest_word, rsp_word_index, rsp_last_word);
      end
   end

   // receiver stall: random, with hold-off stretches on request
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (holdoff_cycles > 0) begin
            rsp_stall <= 1'b1;
            holdoff_cycles--;
         end else if (quiet_phase)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(99) < 31);
         @(negedge clock);
      end
   end

   // send one word and wait for its acceptance
   task automatic send_word(logic [7:0] data, logic present, logic eom);
      while (!quiet_phase && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_byte_present <= present;
      req_end_of_message <= eom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_message(int unsigned len, bit end_with_byte);
      for (int i = 0; i < len; i++)
         send_word(8'($urandom), 1'b1, end_with_byte && i == len - 1);
      if (!end_with_byte || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (digest_sb.pending() != 0) @(negedge clock);
   endtask

   int unsigned len;
   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty message, byte extremes, idle words
      send_word(8'hff, 1'b0, 1'b1);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b0, 1'b0);
      send_word(8'hff, 1'b1, 1'b1);
      send_word(8'h5a, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      drain();

      // boundary lengths around the padding split, then a full block
      send_message(55, 1); send_message(56, 0); send_message(63, 1);
      send_message(64, 0);
      drain();

      // pressure: receiver holds off while sender keeps offering
      holdoff_cycles = 600;
      send_message(3, 1); send_message(0, 0); send_message(2, 0);
      drain();

      // stretch with no idling
      quiet_phase = 1;
      send_message(10, 1); send_message(57, 0);
      quiet_phase = 0;

      // random messages, mostly short, with noise words
      while (words_sent < 430) begin
         case ($urandom_range(9))
            0: len = $urandom_range(130, 60);
            1: send_word(8'($urandom), 1'b0, 1'b0);
            default: len = $urandom_range(12);
         endcase
         send_message(len, 1'($urandom_range(1)));
      end
      drain();
      repeat (300) @(negedge clock);

      if (digest_sb.errors == 0 && digest_sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
